// ===== rtl/rdx_pkg.sv =====
// Shared types, constants and helpers for the radix integer-to-digits block.
// No dependencies; every rtl module refers to it by scoped names.
package rdx_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int DIGIT_W     = 6;
   localparam int RADIX_W     = 6;
   localparam int CHAR_W      = 7;
   localparam int BIT_W       = $clog2(VALUE_BITS);
   localparam int IDX_W       = $clog2(VALUE_BITS);
   localparam int CNT_W       = IDX_W + 1;
   localparam int BANKS       = 2;
   localparam int BANK_W      = $clog2(BANKS);
   localparam int MEM_ADDR_W  = BANK_W + IDX_W;
   localparam int JOB_DEPTH   = 2;
   localparam int JOB_PTR_W   = $clog2(JOB_DEPTH);
   localparam int JOB_LEVEL_W = $clog2(JOB_DEPTH + 1);

   localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
   localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

   localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);   // '0'
   localparam logic [CHAR_W-1:0] CHAR_A    = CHAR_W'(97);   // 'a'
   localparam logic [DIGIT_W-1:0] DEC_MAX  = DIGIT_W'(9);
   localparam logic [DIGIT_W-1:0] DEC_BASE = DIGIT_W'(10);

   typedef enum logic {
      FRONT_IDLE,
      FRONT_DIVIDE
   } front_state_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_EMIT
   } back_state_type;

   // digit store write port, front to back
   typedef struct packed {
      logic                  en;
      logic [MEM_ADDR_W-1:0] addr;
      logic [DIGIT_W-1:0]    data;
   } mem_wr_type;

   // job queue status
   typedef struct packed {
      logic full;
      logic empty;
   } job_stat_type;

   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d > DEC_MAX) begin
         c = CHAR_A + CHAR_W'(d - DEC_BASE);
      end else begin
         c = CHAR_ZERO + CHAR_W'(d);
      end
      return c;
   endfunction

   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] e;
      if (r < RADIX_MIN) begin
         e = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         e = RADIX_MAX;
      end else begin
         e = r;
      end
      return e;
   endfunction

endpackage

// ===== rtl/radix_integer_to_digits_top.sv =====
// Top level of the radix integer-to-digits converter.
// Instantiates rdx_front, rdx_job_queue and rdx_back; uses rdx_pkg.
//
//   channel   ports                                   handshake
//   req       req_value_bits                          req_push / req_full
//   rsp       rsp_digit_char, rsp_is_last             rsp_pop / rsp_empty
//   csr       csr_radix                               csr_we
//
// A nonzero word is divided bit-serially, a pass over all 32 bits per digit, so a word of
// d digits holds the front for d passes (at most 32); a zero word needs no division.
// Digits leave via the registered store read; a read waits for the last to move on.
// The store has two banks: the front takes a new word while the back still drains
// the previous one; req_full rises while it divides or both banks hold unread digits.
// Synchronous reset clears control state only; the digit store needs no clearing pass.
module radix_integer_to_digits_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [rdx_pkg::RADIX_W-1:0]     csr_radix,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [rdx_pkg::VALUE_BITS-1:0]  req_value_bits,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [rdx_pkg::CHAR_W-1:0]      rsp_digit_char,
   output logic                            rsp_is_last
);

   rdx_pkg::job_stat_type      job_stat;
   rdx_pkg::mem_wr_type        mem_wr;
   logic                       job_push;
   logic                       job_pop;
   logic [rdx_pkg::CNT_W-1:0]  push_count;
   logic [rdx_pkg::CNT_W-1:0]  head_count;

   rdx_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_radix      (csr_radix),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_value_bits (req_value_bits),
      .job_stat       (job_stat),
      .job_push       (job_push),
      .job_count      (push_count),
      .mem_wr         (mem_wr)
   );

   rdx_job_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_count (push_count),
      .pop        (job_pop),
      .head_count (head_count),
      .stat       (job_stat)
   );

   rdx_back u_back (
      .clock          (clock),
      .reset          (reset),
      .mem_wr         (mem_wr),
      .job_stat       (job_stat),
      .job_count      (head_count),
      .job_pop        (job_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_digit_char (rsp_digit_char),
      .rsp_is_last    (rsp_is_last)
   );

endmodule

// ===== rtl/rdx_front.sv =====
// Front end: radix register, word intake and bit-serial division by the radix.
// Writes remainders into the digit store and queues a digit count per word. Uses rdx_pkg.
module rdx_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [rdx_pkg::RADIX_W-1:0]       csr_radix,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [rdx_pkg::VALUE_BITS-1:0]    req_value_bits,
   input  rdx_pkg::job_stat_type             job_stat,
   output logic                              job_push,
   output logic [rdx_pkg::CNT_W-1:0]         job_count,
   output rdx_pkg::mem_wr_type               mem_wr
);

   rdx_pkg::front_state_type state_ff, state_in;
   logic [rdx_pkg::RADIX_W-1:0]    radix_ff;
   logic [rdx_pkg::RADIX_W-1:0]    div_ff, div_in;
   logic [rdx_pkg::VALUE_BITS-1:0] val_ff, val_in;
   logic [rdx_pkg::DIGIT_W-1:0]    rem_ff, rem_in;
   logic [rdx_pkg::BIT_W-1:0]      bit_cnt_ff, bit_cnt_in;
   logic [rdx_pkg::IDX_W-1:0]      idx_ff, idx_in;
   logic [rdx_pkg::BANK_W-1:0]     bank_ff, bank_in;

   logic                           accept;
   logic [rdx_pkg::DIGIT_W:0]      trial;
   logic                           q_bit;
   logic [rdx_pkg::DIGIT_W-1:0]    rem_step;
   logic [rdx_pkg::VALUE_BITS-1:0] quot;
   logic                           last_bit;

   assign req_full = (state_ff != rdx_pkg::FRONT_IDLE) || job_stat.full;
   assign accept   = req_push && !req_full;

   // one restoring division step: shift in the next dividend bit, subtract if it fits
   assign trial    = {rem_ff, val_ff[rdx_pkg::VALUE_BITS-1]};
   assign q_bit    = (trial >= {1'b0, div_ff});
   assign rem_step = q_bit ? rdx_pkg::DIGIT_W'(trial - {1'b0, div_ff})
                           : rdx_pkg::DIGIT_W'(trial);
   assign quot     = {val_ff[rdx_pkg::VALUE_BITS-2:0], q_bit};
   assign last_bit = (bit_cnt_ff == rdx_pkg::BIT_W'(rdx_pkg::VALUE_BITS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rdx_pkg::FRONT_IDLE;
         radix_ff <= rdx_pkg::RADIX_RESET;
         bank_ff  <= '0;
      end else begin
         state_ff <= state_in;
         bank_ff  <= bank_in;
         if (csr_we) begin
            radix_ff <= csr_radix;
         end
      end
   end

   always_ff @(posedge clock) begin
      div_ff     <= div_in;
      val_ff     <= val_in;
      rem_ff     <= rem_in;
      bit_cnt_ff <= bit_cnt_in;
      idx_ff     <= idx_in;
   end

   always_comb begin
      state_in   = state_ff;
      div_in     = div_ff;
      val_in     = val_ff;
      rem_in     = rem_ff;
      bit_cnt_in = bit_cnt_ff;
      idx_in     = idx_ff;
      bank_in    = bank_ff;
      job_push   = 1'b0;
      job_count  = '0;
      mem_wr     = '0;
      case (state_ff)
         rdx_pkg::FRONT_IDLE: begin
            if (accept) begin
               div_in     = rdx_pkg::clamp_radix(radix_ff);
               val_in     = req_value_bits;
               rem_in     = '0;
               bit_cnt_in = '0;
               idx_in     = '0;
               if (req_value_bits == '0) begin
                  // zero word: one digit '0', no division
                  mem_wr.en   = 1'b1;
                  mem_wr.addr = {bank_ff, rdx_pkg::IDX_W'(0)};
                  mem_wr.data = '0;
                  job_push    = 1'b1;
                  job_count   = rdx_pkg::CNT_W'(1);
                  bank_in     = bank_ff + 1'b1;
               end else begin
                  state_in = rdx_pkg::FRONT_DIVIDE;
               end
            end
         end
         rdx_pkg::FRONT_DIVIDE: begin
            val_in     = quot;
            rem_in     = rem_step;
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (last_bit) begin
               mem_wr.en   = 1'b1;
               mem_wr.addr = {bank_ff, idx_ff};
               mem_wr.data = rem_step;
               rem_in      = '0;
               idx_in      = idx_ff + 1'b1;
               if (quot == '0) begin
                  job_push  = 1'b1;
                  job_count = rdx_pkg::CNT_W'(idx_ff) + rdx_pkg::CNT_W'(1);
                  bank_in   = bank_ff + 1'b1;
                  state_in  = rdx_pkg::FRONT_IDLE;
               end
            end
         end
         default: begin
            state_in = rdx_pkg::FRONT_IDLE;
         end
      endcase
   end

   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      state_ff == rdx_pkg::FRONT_DIVIDE |-> rem_ff < div_ff)
      else $error("partial remainder reached the divisor");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !job_stat.full)
      else $error("job pushed into a full queue");

   a_divisor_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == rdx_pkg::FRONT_DIVIDE |-> (div_ff >= rdx_pkg::RADIX_MIN &&
                                             div_ff <= rdx_pkg::RADIX_MAX))
      else $error("divisor outside 2..36");

endmodule

// ===== rtl/rdx_job_queue.sv =====
// Short queue of digit counts between the divider front and the emitter back.
// Each entry stands for one bank of the digit store. Uses rdx_pkg.
module rdx_job_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [rdx_pkg::CNT_W-1:0]  push_count,
   input  logic                       pop,
   output logic [rdx_pkg::CNT_W-1:0]  head_count,
   output rdx_pkg::job_stat_type      stat
);

   logic [rdx_pkg::CNT_W-1:0]       entry_ff [rdx_pkg::JOB_DEPTH];
   logic [rdx_pkg::JOB_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [rdx_pkg::JOB_LEVEL_W-1:0] level_ff, level_in;

   assign stat.full  = (level_ff == rdx_pkg::JOB_LEVEL_W'(rdx_pkg::JOB_DEPTH));
   assign stat.empty = (level_ff == '0);
   assign head_count = entry_ff[rd_ptr_ff];

   always_comb begin
      level_in = level_ff;
      case ({push, pop})
         2'b10:   level_in = level_ff + 1'b1;
         2'b01:   level_in = level_ff - 1'b1;
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         level_ff <= level_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_count;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !stat.empty)
      else $error("job popped from an empty queue");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= rdx_pkg::JOB_LEVEL_W'(rdx_pkg::JOB_DEPTH))
      else $error("job queue level overran its depth");

endmodule

// ===== rtl/rdx_back.sv =====
// Back end: two-bank digit store and emitter that reads digits most significant first.
// Registered store read feeds an output register that holds the character until popped. Uses rdx_pkg.
module rdx_back (
   input  logic                             clock,
   input  logic                             reset,
   input  rdx_pkg::mem_wr_type              mem_wr,
   input  rdx_pkg::job_stat_type            job_stat,
   input  logic [rdx_pkg::CNT_W-1:0]        job_count,
   output logic                             job_pop,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [rdx_pkg::CHAR_W-1:0]       rsp_digit_char,
   output logic                             rsp_is_last
);

   localparam int MEM_DEPTH = 1 << rdx_pkg::MEM_ADDR_W;

   logic [rdx_pkg::DIGIT_W-1:0] mem [MEM_DEPTH];

   rdx_pkg::back_state_type state_ff, state_in;
   logic [rdx_pkg::IDX_W-1:0]   k_ff, k_in;
   logic [rdx_pkg::BANK_W-1:0]  bank_ff, bank_in;
   logic                        rd_valid_ff, rd_valid_in;
   logic                        rd_last_ff;
   logic [rdx_pkg::DIGIT_W-1:0] rdata_ff;
   logic                        out_valid_ff, out_valid_in;
   logic [rdx_pkg::CHAR_W-1:0]  out_char_ff;
   logic                        out_last_ff;

   logic pop_fire, out_free, issue, move;

   assign pop_fire = out_valid_ff && rsp_pop;
   assign out_free = !out_valid_ff || pop_fire;
   assign issue    = (state_ff == rdx_pkg::BACK_EMIT) && !rd_valid_ff && out_free;
   assign move     = rd_valid_ff && out_free;

   assign rsp_empty      = !out_valid_ff;
   assign rsp_digit_char = out_char_ff;
   assign rsp_is_last    = out_last_ff;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      bank_in  = bank_ff;
      job_pop  = 1'b0;
      case (state_ff)
         rdx_pkg::BACK_IDLE: begin
            if (!job_stat.empty) begin
               k_in     = rdx_pkg::IDX_W'(job_count - rdx_pkg::CNT_W'(1));
               state_in = rdx_pkg::BACK_EMIT;
            end
         end
         rdx_pkg::BACK_EMIT: begin
            if (issue) begin
               if (k_ff == '0) begin
                  // last digit read: release the bank
                  job_pop  = 1'b1;
                  bank_in  = bank_ff + 1'b1;
                  state_in = rdx_pkg::BACK_IDLE;
               end else begin
                  k_in = k_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = rdx_pkg::BACK_IDLE;
         end
      endcase
      rd_valid_in  = issue ? 1'b1 : (move ? 1'b0 : rd_valid_ff);
      out_valid_in = move ? 1'b1 : (pop_fire ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rdx_pkg::BACK_IDLE;
         bank_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      if (issue) begin
         rd_last_ff <= (k_ff == '0);
      end
      if (move) begin
         out_char_ff <= rdx_pkg::digit_to_char(rdata_ff);
         out_last_ff <= rd_last_ff;
      end
   end

   // digit store: one write port from the front, one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         mem[mem_wr.addr] <= mem_wr.data;
      end
      if (issue) begin
         rdata_ff <= mem[{bank_ff, k_ff}];
      end
   end

   a_fetch_lands: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff && !out_valid_ff |=> out_valid_ff)
      else $error("fetched digit did not reach the output register");

endmodule
